[rtl/lbcg_pkg.sv]
package lbcg_pkg;

  // Time counters
  localparam int TIME_BITS = 32;

  // APB register map
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_POLL_PERIOD = 3'd0,
    REG_LONG_ON     = 3'd1,
    REG_SHORT_ON    = 3'd2,
    REG_OFF         = 3'd3,
    REG_ACTIVE_HIGH = 3'd4
  } reg_idx_t;

  // Reset values of the configuration registers
  localparam logic [9:0]  POLL_PERIOD_RST = 10'd50;
  localparam logic [15:0] LONG_ON_RST     = 16'd2000;
  localparam logic [15:0] SHORT_ON_RST    = 16'd500;
  localparam logic [15:0] OFF_RST         = 16'd500;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_LEVEL  = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_VALUE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [9:0]  poll_period_ms;
    logic [15:0] long_on_ms;
    logic [15:0] short_on_ms;
    logic [15:0] off_ms;
    logic        active_high;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        level;
    logic [15:0] half_period;
    logic [7:0]  blink_count;
  } item_t;

  typedef struct packed {
    logic pin_level;
    logic pin_changed;
  } result_t;

endpackage

[rtl/lbcg_if.sv]
// Command / tick channel
interface lbcg_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        level;
  logic [15:0] half_period;
  logic [7:0]  blink_count;

  modport source (output valid, output cmd, output level, output half_period,
                  output blink_count, input ready);
  modport sink   (input valid, input cmd, input level, input half_period,
                  input blink_count, output ready);
endinterface

// Pin result channel
interface lbcg_result_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic pin_changed;

  modport source (output valid, output pin_level, output pin_changed, input ready);
  modport sink   (input valid, input pin_level, input pin_changed, output ready);
endinterface

[rtl/lbcg_cfg_regs.sv]
module lbcg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbcg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [lbcg_pkg::DATA_BITS-1:0] pwdata,
  output logic [lbcg_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  output lbcg_pkg::cfg_t                 cfg
);
  import lbcg_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  // Register writes; addresses beyond the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_period_ms <= POLL_PERIOD_RST;
      cfg.long_on_ms     <= LONG_ON_RST;
      cfg.short_on_ms    <= SHORT_ON_RST;
      cfg.off_ms         <= OFF_RST;
      cfg.active_high    <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        REG_POLL_PERIOD: cfg.poll_period_ms <= pwdata[9:0];
        REG_LONG_ON:     cfg.long_on_ms     <= pwdata[15:0];
        REG_SHORT_ON:    cfg.short_on_ms    <= pwdata[15:0];
        REG_OFF:         cfg.off_ms         <= pwdata[15:0];
        REG_ACTIVE_HIGH: cfg.active_high    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (idx)
      REG_POLL_PERIOD: prdata = DATA_BITS'(cfg.poll_period_ms);
      REG_LONG_ON:     prdata = DATA_BITS'(cfg.long_on_ms);
      REG_SHORT_ON:    prdata = DATA_BITS'(cfg.short_on_ms);
      REG_OFF:         prdata = DATA_BITS'(cfg.off_ms);
      REG_ACTIVE_HIGH: prdata = DATA_BITS'(cfg.active_high);
      default:         prdata = '0;
    endcase
  end

endmodule

[rtl/lbcg_core.sv]
module lbcg_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  lbcg_pkg::item_t   item,
  input  lbcg_pkg::cfg_t    cfg,
  output lbcg_pkg::result_t res
);
  import lbcg_pkg::*;

  typedef enum logic [2:0] {
    MODE_DIRECT = 3'b001,
    MODE_TOGGLE = 3'b010,
    MODE_VALUE  = 3'b100
  } mode_t;

  // LED state
  mode_t                run_mode, run_mode_next;
  logic                 led_on, led_on_next;
  logic [TIME_BITS-1:0] now_ms, now_ms_next;
  logic [TIME_BITS-1:0] deadline_ms, deadline_ms_next;
  logic [15:0]          toggle_period, toggle_period_next;
  logic [7:0]           shown_count, shown_count_next;
  logic [9:0]           phase_index, phase_index_next;

  logic [TIME_BITS-1:0] now_tick;
  logic [TIME_BITS-1:0] diff;
  logic                 reached;
  logic [15:0]          poll_ext;
  logic [15:0]          clamped;
  logic [9:0]           limit;
  logic [9:0]           phase_inc;
  logic [9:0]           phase_wrap;
  logic [15:0]          phase_len;
  logic                 changed;

  // Shared datapath terms
  assign now_tick   = now_ms + TIME_BITS'(cfg.poll_period_ms);
  assign diff       = now_tick - deadline_ms;
  assign reached    = !diff[TIME_BITS-1];
  assign poll_ext   = 16'(cfg.poll_period_ms);
  assign clamped    = (item.half_period < poll_ext) ? poll_ext : item.half_period;
  assign limit      = {({1'b0, shown_count} + 9'd1), 1'b0};
  assign phase_inc  = phase_index + 10'd1;
  assign phase_wrap = (phase_inc >= limit) ? '0 : phase_inc;

  always_comb begin
    if (phase_wrap == '0)  phase_len = cfg.long_on_ms;
    else if (!phase_wrap[0]) phase_len = cfg.short_on_ms;
    else                   phase_len = cfg.off_ms;
  end

  // Next state for one item
  always_comb begin
    run_mode_next      = run_mode;
    led_on_next        = led_on;
    now_ms_next        = now_ms;
    deadline_ms_next   = deadline_ms;
    toggle_period_next = toggle_period;
    shown_count_next   = shown_count;
    phase_index_next   = phase_index;
    changed            = 1'b0;
    case (item.cmd)
      CMD_TICK: begin
        now_ms_next = now_tick;
        unique case (run_mode)
          MODE_TOGGLE: begin
            if (reached) begin
              led_on_next      = !led_on;
              changed          = 1'b1;
              deadline_ms_next = deadline_ms + TIME_BITS'(toggle_period);
            end
          end
          MODE_VALUE: begin
            if (reached) begin
              led_on_next      = !led_on;
              changed          = 1'b1;
              phase_index_next = phase_wrap;
              deadline_ms_next = deadline_ms + TIME_BITS'(phase_len);
            end
          end
          default: ;
        endcase
      end
      CMD_LEVEL: begin
        run_mode_next = MODE_DIRECT;
        led_on_next   = item.level;
        changed       = 1'b1;
      end
      CMD_TOGGLE: begin
        if (run_mode != MODE_TOGGLE || toggle_period != clamped) begin
          run_mode_next      = MODE_TOGGLE;
          deadline_ms_next   = now_ms + TIME_BITS'(clamped);
          toggle_period_next = clamped;
        end
      end
      default: begin
        // blink code start, ignored when the same count is already shown
        if (run_mode != MODE_VALUE || shown_count != item.blink_count) begin
          run_mode_next    = MODE_VALUE;
          shown_count_next = item.blink_count;
          phase_index_next = '0;
          deadline_ms_next = now_ms + TIME_BITS'(cfg.long_on_ms);
          led_on_next      = 1'b0;
          changed          = 1'b1;
        end
      end
    endcase
  end

  assign res.pin_level   = led_on_next ^ !cfg.active_high;
  assign res.pin_changed = changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= MODE_DIRECT;
      led_on        <= 1'b0;
      now_ms        <= '0;
      deadline_ms   <= '0;
      toggle_period <= '0;
      shown_count   <= '0;
      phase_index   <= '0;
    end else if (fire) begin
      run_mode      <= run_mode_next;
      led_on        <= led_on_next;
      now_ms        <= now_ms_next;
      deadline_ms   <= deadline_ms_next;
      toggle_period <= toggle_period_next;
      shown_count   <= shown_count_next;
      phase_index   <= phase_index_next;
    end
  end

endmodule

[rtl/led_blink_code_generator_unit.sv]
// Channel  | Dir | Payload                                   | Transfer
// items    | in  | cmd, level, half_period, blink_count      | valid & ready
// results  | out | pin_level, pin_changed                    | valid & ready
// apb      | in  | paddr, pwdata (prdata back), pready tied 1| psel & penable
//
// One item per cycle sustained while results are taken: an input register
// feeds the state update, and the result lands in an output register, so an
// item passes the input register and then the result register before transfer.
// The state update is a single pass (one 32-bit add and compare per path).
// Reset (rst, synchronous) clears state, registers go to their defaults.
// A stalled result holds its register; the input register keeps accepting
// until it too is full.
module led_blink_code_generator_unit (
  input  logic                           clk,
  input  logic                           rst,
  lbcg_item_if.sink                      items,
  lbcg_result_if.source                  results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbcg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [lbcg_pkg::DATA_BITS-1:0] pwdata,
  output logic [lbcg_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);
  import lbcg_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t res;
  result_t o_res;
  logic    o_valid;

  lbcg_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  assign advance     = s1_valid && (!o_valid || results.ready);
  assign items.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_item.cmd         <= cmd_t'(items.cmd);
      s1_item.level       <= items.level;
      s1_item.half_period <= items.half_period;
      s1_item.blink_count <= items.blink_count;
    end
  end

  lbcg_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_res <= res;
    end
  end

  assign results.valid       = o_valid;
  assign results.pin_level   = o_res.pin_level;
  assign results.pin_changed = o_res.pin_changed;

endmodule

[rtl/lbcg_checker.sv]
module lbcg_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pin_level,
  input logic pin_changed
);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pin_level) && $stable(pin_changed))
    else $error("result payload changed while stalled");

  // An empty output side never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // An input transfer while the result register is empty yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_ready && in_valid |=> ##1 out_valid)
    else $error("result missing after transfer");

endmodule

bind led_blink_code_generator_unit lbcg_checker u_lbcg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .pin_level   (results.pin_level),
  .pin_changed (results.pin_changed)
);

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbcg_pkg::*;

  // Run modes of the LED driver
  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_TOGGLE = 2'd1;
  localparam logic [1:0] MODE_VALUE  = 2'd2;

  localparam int STALL_PCT = 14;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  lbcg_item_if   item_ch ();
  lbcg_result_if res_ch ();

  led_blink_code_generator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Items waiting to go out, and pin results predicted for accepted items
  item_t   pending_items[$];
  result_t pin_forecast[$];
  int      queued_count   = 0;
  int      accepted_count = 0;
  int      mismatch_count = 0;
  logic    item_fire      = 1'b0;
  logic    calm           = 1'b0;
  item_t   drv_item;

  // Shadow of the register file and of the LED state
  cfg_t                 cfg_now;
  logic [1:0]           run_mode;
  logic                 led_on;
  logic [TIME_BITS-1:0] now_ms;
  logic [TIME_BITS-1:0] deadline_ms;
  logic [15:0]          toggle_period;
  logic [7:0]           shown_count;
  logic [9:0]           phase_index;

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Wrap-safe: reached when now - deadline has its top bit clear
  function automatic logic deadline_hit();
    logic [TIME_BITS-1:0] diff;
    diff = now_ms - deadline_ms;
    return !diff[TIME_BITS-1];
  endfunction

  // Next pin state for one command or tick
  task automatic step_led(input item_t it, output result_t r);
    logic [15:0] p;
    int          lim;
    logic        chg;
    chg = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        now_ms = now_ms + cfg_now.poll_period_ms;
        if (run_mode == MODE_TOGGLE && deadline_hit()) begin
          led_on      = ~led_on;
          chg         = 1'b1;
          deadline_ms = deadline_ms + toggle_period;
        end else if (run_mode == MODE_VALUE && deadline_hit()) begin
          lim         = (int'(shown_count) + 1) * 2;
          led_on      = ~led_on;
          chg         = 1'b1;
          phase_index = phase_index + 10'd1;
          if (int'(phase_index) >= lim) phase_index = '0;
          if (phase_index == 0)
            deadline_ms = deadline_ms + cfg_now.long_on_ms;
          else if (!phase_index[0])
            deadline_ms = deadline_ms + cfg_now.short_on_ms;
          else
            deadline_ms = deadline_ms + cfg_now.off_ms;
        end
      end
      CMD_LEVEL: begin
        run_mode = MODE_DIRECT;
        led_on   = it.level;
        chg      = 1'b1;
      end
      CMD_TOGGLE: begin
        // short periods are raised to the poll period
        p = (it.half_period < {6'd0, cfg_now.poll_period_ms}) ?
            {6'd0, cfg_now.poll_period_ms} : it.half_period;
        if (run_mode != MODE_TOGGLE || toggle_period != p) begin
          run_mode      = MODE_TOGGLE;
          deadline_ms   = now_ms + p;
          toggle_period = p;
        end
      end
      default: begin
        if (run_mode != MODE_VALUE || shown_count != it.blink_count) begin
          run_mode    = MODE_VALUE;
          shown_count = it.blink_count;
          phase_index = '0;
          deadline_ms = now_ms + cfg_now.long_on_ms;
          led_on      = 1'b0;
          chg         = 1'b1;
        end
      end
    endcase
    r.pin_level   = led_on ^ ~cfg_now.active_high;
    r.pin_changed = chg;
  endtask

  // Item driver: a new item only once the current one has transferred
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_fire) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99, 0) >= STALL_PCT)) begin
        drv_item = pending_items.pop_front();
        item_ch.cmd         <= drv_item.cmd;
        item_ch.level       <= drv_item.level;
        item_ch.half_period <= drv_item.half_period;
        item_ch.blink_count <= drv_item.blink_count;
        item_ch.valid       <= 1'b1;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= calm || ($urandom_range(99, 0) >= STALL_PCT);
  end

  // Monitor: check results, then predict for the item taken at this edge
  always @(posedge clk) begin : monitor
    item_t   seen;
    result_t want;
    item_fire <= !rst && item_ch.valid && item_ch.ready;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pin_forecast.size() == 0) begin
          flag_error($sformatf("result with nothing pending: pin_level %0b pin_changed %0b",
                               res_ch.pin_level, res_ch.pin_changed));
        end else begin
          want = pin_forecast.pop_front();
          if (res_ch.pin_level !== want.pin_level)
            flag_error($sformatf("pin_level expected %0b got %0b",
                                 want.pin_level, res_ch.pin_level));
          if (res_ch.pin_changed !== want.pin_changed)
            flag_error($sformatf("pin_changed expected %0b got %0b",
                                 want.pin_changed, res_ch.pin_changed));
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        seen.cmd         = cmd_t'(item_ch.cmd);
        seen.level       = item_ch.level;
        seen.half_period = item_ch.half_period;
        seen.blink_count = item_ch.blink_count;
        step_led(seen, want);
        pin_forecast.push_back(want);
        accepted_count++;
      end
    end
  end

  task automatic add_item(input cmd_t c, input logic lv, input logic [15:0] pm,
                          input logic [7:0] bc);
    item_t it;
    it.cmd         = c;
    it.level       = lv;
    it.half_period = pm;
    it.blink_count = bc;
    pending_items.push_back(it);
    queued_count++;
  endtask

  // Ticks carry random junk in the unused fields
  task automatic add_ticks(input int n);
    repeat (n) add_item(CMD_TICK, 1'($urandom()), 16'($urandom()), 8'($urandom()));
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_POLL_PERIOD: cfg_now.poll_period_ms = val[9:0];
      REG_LONG_ON:     cfg_now.long_on_ms     = val[15:0];
      REG_SHORT_ON:    cfg_now.short_on_ms    = val[15:0];
      REG_OFF:         cfg_now.off_ms         = val[15:0];
      REG_ACTIVE_HIGH: cfg_now.active_high    = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [9:0] poll, input logic [15:0] lo,
                          input logic [15:0] sh, input logic [15:0] of, input logic ah);
    write_reg(REG_POLL_PERIOD, {22'd0, poll});
    write_reg(REG_LONG_ON,     {16'd0, lo});
    write_reg(REG_SHORT_ON,    {16'd0, sh});
    write_reg(REG_OFF,         {16'd0, of});
    write_reg(REG_ACTIVE_HIGH, {31'd0, ah});
  endtask

  // Wait until every queued item has transferred and its result is checked
  task automatic drain();
    while (accepted_count != queued_count || pin_forecast.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Mostly a command followed by a run of ticks, some noise
  task automatic random_items(input int n);
    int          stop_at;
    int          pick;
    logic [7:0]  cnt;
    logic [15:0] per;
    stop_at = queued_count + n;
    while (queued_count < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
        cnt = ($urandom_range(9, 0) < 7) ? 8'($urandom_range(5, 0)) : 8'($urandom());
        add_item(CMD_VALUE, 1'($urandom()), 16'($urandom()), cnt);
        if ($urandom_range(4, 0) == 0)
          add_item(CMD_VALUE, 1'($urandom()), 16'($urandom()), cnt);
        add_ticks($urandom_range(40, 5));
      end else if (pick < 75) begin
        per = ($urandom_range(3, 0) == 0) ? 16'($urandom()) :
              16'(cfg_now.poll_period_ms * $urandom_range(4, 0));
        add_item(CMD_TOGGLE, 1'($urandom()), per, 8'($urandom()));
        if ($urandom_range(4, 0) == 0)
          add_item(CMD_TOGGLE, 1'($urandom()), per, 8'($urandom()));
        add_ticks($urandom_range(20, 3));
      end else if (pick < 85) begin
        add_item(CMD_LEVEL, 1'($urandom()), 16'($urandom()), 8'($urandom()));
        add_ticks($urandom_range(3, 0));
      end else begin
        add_item(cmd_t'($urandom_range(3, 0)), 1'($urandom()), 16'($urandom()),
                 8'($urandom()));
      end
    end
  endtask

  task automatic random_phase(input logic is_calm);
    logic [9:0] poll;
    poll = 10'($urandom_range(1000, 1));
    set_regs(poll,
             16'(poll * $urandom_range(3, 1) + $urandom_range(int'(poll) - 1, 0)),
             16'(poll * $urandom_range(2, 0) + $urandom_range(int'(poll) - 1, 0)),
             16'(poll * $urandom_range(2, 1)),
             1'($urandom()));
    calm = is_calm;
    random_items(35);
    drain();
    calm = 1'b0;
  endtask

  initial begin
    clk     = 1'b0;
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    item_ch.valid       = 1'b0;
    item_ch.cmd         = CMD_TICK;
    item_ch.level       = 1'b0;
    item_ch.half_period = '0;
    item_ch.blink_count = '0;
    res_ch.ready        = 1'b0;

    cfg_now.poll_period_ms = POLL_PERIOD_RST;
    cfg_now.long_on_ms     = LONG_ON_RST;
    cfg_now.short_on_ms    = SHORT_ON_RST;
    cfg_now.off_ms         = OFF_RST;
    cfg_now.active_high    = 1'b1;
    run_mode      = MODE_DIRECT;
    led_on        = 1'b0;
    now_ms        = '0;
    deadline_ms   = '0;
    toggle_period = '0;
    shown_count   = '0;
    phase_index   = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, on reset register values
    add_item(CMD_LEVEL, 1'b1, 16'hFFFF, 8'hFF);
    add_item(CMD_LEVEL, 1'b0, 16'h0000, 8'h00);
    add_ticks(1);                                  // direct mode: time only
    add_item(CMD_TOGGLE, 1'b0, 16'd0, 8'd0);        // clamped up to poll period
    add_ticks(3);
    add_item(CMD_TOGGLE, 1'b1, 16'd50, 8'd0);       // same clamped period: no restart
    add_ticks(1);
    add_item(CMD_TOGGLE, 1'b0, 16'hFFFF, 8'd0);
    add_ticks(2);
    add_item(CMD_TOGGLE, 1'b0, 16'd10, 8'd0);
    add_ticks(1);
    add_item(CMD_VALUE, 1'b0, 16'd0, 8'd0);
    add_item(CMD_VALUE, 1'b1, 16'hFFFF, 8'd0);      // same count: no restart
    add_ticks(2);
    add_item(CMD_VALUE, 1'b0, 16'd0, 8'hFF);
    add_ticks(2);
    add_item(CMD_LEVEL, 1'b1, 16'd0, 8'd0);
    add_item(CMD_VALUE, 1'b1, 16'd0, 8'hFF);
    drain();

    // Extremes of the register ranges, including zero
    set_regs(10'd1000, 16'd1, 16'd1, 16'd1, 1'b0);
    random_items(30);
    drain();
    set_regs(10'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    random_items(25);
    drain();
    set_regs(10'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    random_items(25);
    drain();
    set_regs(10'h3FF, 16'd0, 16'd0, 16'd0, 1'b0);
    random_items(20);
    drain();

    // Random settings, one phase with no stalls at all
    random_phase(1'b0);
    random_phase(1'b0);
    random_phase(1'b1);
    random_phase(1'b0);
    random_phase(1'b0);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end

endmodule
